>>> hw/rtl/cht_pkg.sv
// cuckoo hash table package: sizes, codes, memory entry and hash unit types
// used by cht_hash and cuckoo_hash_table_core, no dependencies
`timescale 1ns / 1ps

package cht_pkg;

    // table geometry, TABLE_SIZE must be a power of two
    localparam int TABLE_SIZE = 1024;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int MAX_KICKS  = 32;
    localparam int KICK_W     = $clog2(MAX_KICKS + 1);

    localparam logic [32:0] HASH_PRIME = 33'd4294967291;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [KICK_W-1:0] kick_t;

    // request opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_CHAINERR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MULT_FIRST    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_FIRST  = 2'd1;
    localparam logic [1:0] CFG_MULT_SECOND   = 2'd2;
    localparam logic [1:0] CFG_OFFSET_SECOND = 2'd3;

    // one table slot
    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] value;
    } entry_t;

    // hash unit status toward the controller
    typedef struct packed {
        logic  done;
        logic  busy;
        addr_t index;
    } hash_res_t;

endpackage

>>> hw/rtl/cht_hash.sv
// multi-cycle hash unit: xorshift, 64-bit multiply-add from 32x32 partial
// products, reduction mod 4294967291 and mod table size; uses cht_pkg
`timescale 1ns / 1ps

module cht_hash
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       key,
    input  logic [63:0]       mult,
    input  logic [63:0]       offset,
    output cht_pkg::hash_res_t res
);
    import cht_pkg::*;

    logic [63:0] k_reg;
    logic [63:0] acc_reg;
    logic [2:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    addr_t       index_reg;

    logic [63:0] kext;
    logic [63:0] kmix;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;
    logic [34:0] fold1;
    logic [32:0] fold2;
    logic [32:0] reduced;

    // sign extension and xorshift mix of the incoming key
    assign kext = {{32{key[31]}}, key};
    assign kmix = kext ^ (kext << 7) ^ (kext << 13);

    // one shared 32x32 multiplier for the three low partial products
    always_comb
    begin
        case (step_reg)
            3'd0:    begin op_a = k_reg[31:0];  op_b = mult[31:0];  end
            3'd1:    begin op_a = k_reg[31:0];  op_b = mult[63:32]; end
            default: begin op_a = k_reg[63:32]; op_b = mult[31:0];  end
        endcase
    end
    assign prod = {32'd0, op_a} * {32'd0, op_b};

    // 2^32 == 5 mod prime, so fold the high word twice then one subtract
    assign fold1   = ({3'd0, acc_reg[63:32]} << 2) + {3'd0, acc_reg[63:32]}
                     + {3'd0, acc_reg[31:0]};
    assign fold2   = ({30'd0, acc_reg[34:32]} << 2) + {30'd0, acc_reg[34:32]}
                     + {1'b0, acc_reg[31:0]};
    assign reduced = (fold2 >= HASH_PRIME) ? (fold2 - HASH_PRIME) : fold2;

    // step sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= 3'd0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            k_reg <= kmix;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                3'd0:    acc_reg <= prod;
                3'd1:    acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];
                3'd2:    acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];
                3'd3:    acc_reg <= acc_reg + offset;
                3'd4:    acc_reg <= {29'd0, fold1};
                default: index_reg <= reduced[ADDR_W-1:0];
            endcase
        end
    end

    assign res.done  = done_reg;
    assign res.busy  = busy_reg;
    assign res.index = index_reg;

endmodule

>>> hw/rtl/cuckoo_hash_table_core.sv
// two-way cuckoo hash table, one request at a time, one result per request
// result path: a lookup hit in the first slot skips the second check, miss and
// delete check both slots, unused opcode skips the hash wait, insert rehashes per kick
// next request: taken in the cycle after the result is registered
// reset: config to mult 1 / offset 0, then a clearing pass over all 1024
// slots of the memory while no request is taken; depends on cht_pkg, cht_hash
`timescale 1ns / 1ps

module cuckoo_hash_table_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] key_in,
    input  logic signed [31:0] value_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] value_out,
    output logic signed [31:0] dropped_key,
    output logic signed [31:0] dropped_value
);
    import cht_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_HASH  = 8'b00000100,
        S_ICHK  = 8'b00001000,
        S_IHASH = 8'b00010000,
        S_CHK0  = 8'b00100000,
        S_CHK1  = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t      state_reg, state_next;

    logic [63:0] mult_first_reg, offset_first_reg;
    logic [63:0] mult_second_reg, offset_second_reg;

    logic [1:0]  op_reg;
    logic [31:0] cur_key_reg, cur_val_reg;
    addr_t       pos_reg;
    kick_t       kick_reg;
    addr_t       clr_reg;

    logic [1:0]  res_status_reg;
    logic [31:0] res_value_reg, res_dkey_reg, res_dval_reg;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] value_out_reg, dropped_key_reg, dropped_value_reg;

    // slot memory, one write and one registered read port
    entry_t      mem [TABLE_SIZE];
    entry_t      rd_data_reg;
    logic        mem_we;
    addr_t       mem_waddr;
    entry_t      mem_wdata;
    addr_t       mem_raddr;

    logic        hash_start;
    logic [31:0] hash_key;
    hash_res_t   h0_res, h1_res;

    logic        accept;
    logic        hit;
    logic        out_free;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign hit      = rd_data_reg.valid && (rd_data_reg.key == cur_key_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // hash units for both functions, run side by side on the same key
    cht_hash u_hash0
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (hash_key),
        .mult   (mult_first_reg),
        .offset (offset_first_reg),
        .res    (h0_res)
    );

    cht_hash u_hash1
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (hash_key),
        .mult   (mult_second_reg),
        .offset (offset_second_reg),
        .res    (h1_res)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_first_reg    <= 64'd1;
            offset_first_reg  <= 64'd0;
            mult_second_reg   <= 64'd1;
            offset_second_reg <= 64'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MULT_FIRST:    mult_first_reg    <= cfg_data;
                CFG_OFFSET_FIRST:  offset_first_reg  <= cfg_data;
                CFG_MULT_SECOND:   mult_second_reg   <= cfg_data;
                CFG_OFFSET_SECOND: offset_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control: next state, hash start, memory ports
    always_comb
    begin
        state_next = state_reg;
        hash_start = 1'b0;
        hash_key   = cur_key_reg;
        mem_we     = 1'b0;
        mem_waddr  = pos_reg;
        mem_wdata  = '{valid: 1'b1, key: cur_key_reg, value: cur_val_reg};
        mem_raddr  = h0_res.index;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == addr_t'(TABLE_SIZE - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                hash_key = key_in;
                if (accept)
                begin
                    hash_start = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                mem_raddr = h0_res.index;
                if (op_reg != OP_INSERT && op_reg != OP_DELETE && op_reg != OP_LOOKUP)
                    state_next = S_OUT;
                else if (h0_res.done)
                    state_next = (op_reg == OP_INSERT) ? S_ICHK : S_CHK0;
            end
            S_ICHK:
            begin
                // place here, or swap with the occupant
                mem_we   = 1'b1;
                hash_key = rd_data_reg.key;
                if (hit || !rd_data_reg.valid)
                    state_next = S_OUT;
                else
                begin
                    hash_start = 1'b1;
                    state_next = S_IHASH;
                end
            end
            S_IHASH:
            begin
                mem_raddr = h1_res.index;
                if (h0_res.done)
                begin
                    if (h0_res.index != pos_reg || kick_reg == kick_t'(MAX_KICKS))
                        state_next = S_OUT;
                    else
                        state_next = S_ICHK;
                end
            end
            S_CHK0:
            begin
                mem_raddr = h1_res.index;
                mem_waddr = h0_res.index;
                mem_wdata = '{valid: 1'b0, key: rd_data_reg.key, value: rd_data_reg.value};
                mem_we    = hit && (op_reg == OP_DELETE);
                state_next = (hit && op_reg == OP_LOOKUP) ? S_OUT : S_CHK1;
            end
            S_CHK1:
            begin
                mem_waddr = h1_res.index;
                mem_wdata = '{valid: 1'b0, key: rd_data_reg.key, value: rd_data_reg.value};
                mem_we    = hit && (op_reg == OP_DELETE);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            kick_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + addr_t'(1);
            if (accept)
                kick_reg <= '0;
            else if (state_reg == S_ICHK && hash_start)
                kick_reg <= kick_reg + kick_t'(1);
        end
    end

    // request payload and result staging
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= opcode;
            cur_key_reg    <= key_in;
            cur_val_reg    <= value_in;
            res_status_reg <= ST_DONE;
            res_value_reg  <= '0;
            res_dkey_reg   <= '0;
            res_dval_reg   <= '0;
        end
        unique case (state_reg)
            S_HASH:
                pos_reg <= h0_res.index;
            S_ICHK:
            begin
                if (!hit && rd_data_reg.valid)
                begin
                    cur_key_reg <= rd_data_reg.key;
                    cur_val_reg <= rd_data_reg.value;
                end
            end
            S_IHASH:
            begin
                if (h0_res.done)
                begin
                    pos_reg <= h1_res.index;
                    if (h0_res.index != pos_reg || kick_reg == kick_t'(MAX_KICKS))
                    begin
                        res_status_reg <= ST_CHAINERR;
                        res_dkey_reg   <= cur_key_reg;
                        res_dval_reg   <= cur_val_reg;
                    end
                end
            end
            S_CHK0:
            begin
                if (hit && op_reg == OP_LOOKUP)
                    res_value_reg <= rd_data_reg.value;
            end
            S_CHK1:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    if (hit)
                        res_value_reg <= rd_data_reg.value;
                    else
                        res_status_reg <= ST_MISS;
                end
            end
            default: ;
        endcase
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            status_reg        <= res_status_reg;
            value_out_reg     <= res_value_reg;
            dropped_key_reg   <= res_dkey_reg;
            dropped_value_reg <= res_dval_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign value_out     = value_out_reg;
    assign dropped_key   = dropped_key_reg;
    assign dropped_value = dropped_value_reg;

    // checks
    a_hash_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        h0_res.done == h1_res.done)
        else $error("hash units out of step");

    a_kick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kick_reg <= kick_t'(MAX_KICKS))
        else $error("kick count beyond bound");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_OUT) |-> !mem_we)
        else $error("slot write outside a request");

    a_accept_starts_hash: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_HASH) && h0_res.busy)
        else $error("accepted request did not start hashing");

endmodule
